// ===== design/lbct_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block cache tags package
// Shared types and operation codes for the tag unit and its cells.
// ----------------------------------------------------------------------------
package lbct_pkg;

    // Operation codes carried by a request.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_LOCK   = 1'b1;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Flags of the search record that travels down the chain of cells.
    typedef struct packed {
        logic busy;      // a search record is present at this position
        logic hit;       // a valid matching entry has been found
        logic hit_lock;  // the matching entry is locked
        logic vic;       // an unlocked victim candidate has been found
    } t_scan_flags;

    // Update command broadcast to every cell at the end of a request.
    typedef struct packed {
        logic promote;   // make the addressed entry most recently used
        logic retag;     // write the block number into the addressed entry
        logic lock;      // lock the addressed entry
    } t_cell_upd;

endpackage

// ===== design/lbct_cell.sv =====
// ----------------------------------------------------------------------------
// LRU block cache tags cell
// One cache entry: tag, valid, lock and recency rank. It evaluates the search
// record handed in by its left neighbor and passes the updated record on.
// ----------------------------------------------------------------------------
module lbct_cell #(
    parameter int ENTRIES = 16,
    parameter int IDX     = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [31:0]               i_blk,
    input  lbct_pkg::t_scan_flags     i_flags,
    input  logic [$clog2(ENTRIES)-1:0] i_hit_idx,
    input  logic [$clog2(ENTRIES)-1:0] i_hit_rank,
    input  logic [$clog2(ENTRIES)-1:0] i_vic_idx,
    input  logic [$clog2(ENTRIES)-1:0] i_vic_rank,
    output lbct_pkg::t_scan_flags     o_flags,
    output logic [$clog2(ENTRIES)-1:0] o_hit_idx,
    output logic [$clog2(ENTRIES)-1:0] o_hit_rank,
    output logic [$clog2(ENTRIES)-1:0] o_vic_idx,
    output logic [$clog2(ENTRIES)-1:0] o_vic_rank,
    input  lbct_pkg::t_cell_upd       i_upd,
    input  logic [$clog2(ENTRIES)-1:0] i_upd_idx,
    input  logic [$clog2(ENTRIES)-1:0] i_upd_rank
);
    import lbct_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
    localparam logic [IW-1:0] TOP_RANK = IW'(ENTRIES - 1);

    logic [31:0]   r_tag;
    logic          r_valid;
    logic          r_locked;
    logic [IW-1:0] r_rank;

    t_scan_flags   r_flags, n_flags;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [IW-1:0] r_hit_rank, n_hit_rank;
    logic [IW-1:0] r_vic_idx, n_vic_idx;
    logic [IW-1:0] r_vic_rank, n_vic_rank;

    logic w_match;
    logic w_better;
    logic w_mine;

    assign w_match  = r_valid && (r_tag == i_blk);
    assign w_better = !r_locked && (!i_flags.vic || (r_rank < i_vic_rank));
    assign w_mine   = (i_upd_idx == MY_IDX);

    // Search step: keep the first hit and the lowest ranked unlocked entry.
    always_comb begin
        n_flags    = i_flags;
        n_hit_idx  = i_hit_idx;
        n_hit_rank = i_hit_rank;
        n_vic_idx  = i_vic_idx;
        n_vic_rank = i_vic_rank;
        if (i_flags.busy && !i_flags.hit && w_match) begin
            n_flags.hit      = 1'b1;
            n_flags.hit_lock = r_locked;
            n_hit_idx        = MY_IDX;
            n_hit_rank       = r_rank;
        end
        if (i_flags.busy && w_better) begin
            n_flags.vic = 1'b1;
            n_vic_idx   = MY_IDX;
            n_vic_rank  = r_rank;
        end
    end

    // The busy flag is control state; the rest of the record is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_vic_idx  <= n_vic_idx;
        r_vic_rank <= n_vic_rank;
    end

    // Entry state: valid, lock and rank reset; the tag is written on a fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_locked <= 1'b0;
            r_rank   <= MY_IDX;
        end else begin
            if (i_upd.retag && w_mine) begin
                r_valid <= 1'b1;
            end
            if (i_upd.lock && w_mine) begin
                r_locked <= 1'b1;
            end
            if (i_upd.promote) begin
                if (w_mine) begin
                    r_rank <= TOP_RANK;
                end else if (r_rank > i_upd_rank) begin
                    r_rank <= r_rank - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.retag && w_mine) begin
            r_tag <= i_blk;
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_rank = r_hit_rank;
    assign o_vic_idx  = r_vic_idx;
    assign o_vic_rank = r_vic_rank;

endmodule

// ===== design/lru_block_cache_tags_unit.sv =====
// ----------------------------------------------------------------------------
// LRU block cache tags unit
// Tag and replacement manager for a fully associative block cache with
// permanent entry locking, built as a chain of one cell per entry.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  request   i_valid / o_stall    i_operation, i_block_number, i_entry_index
//  result    o_valid / i_stall    o_slot, o_hit, o_fill_needed, o_no_victim
//
// A lookup launches a search record into the first cell, passes it through
// the register of every cell in turn, and commits the update and the result
// once the record leaves the last cell. A lock goes straight to the commit.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted and searched.
// A stalled result holds the commit of the next request until it is taken.
// Reset clears all valid and lock bits and sets entry i to rank i.
//
module lru_block_cache_tags_unit #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_block_number,
    input  logic [3:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_slot,
    output logic        o_hit,
    output logic        o_fill_needed,
    output logic        o_no_victim
);
    import lbct_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    t_state r_state, n_state;

    // Request registers.
    logic        r_op;
    logic [31:0] r_blk;
    logic [3:0]  r_entry;

    // Captured search result.
    t_scan_flags   r_res;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_hit_rank;
    logic [IW-1:0] r_vic_idx;
    logic [IW-1:0] r_vic_rank;

    // Output register.
    logic        r_out_valid;
    logic [3:0]  r_slot;
    logic        r_hit;
    logic        r_fill;
    logic        r_no_vic;
    logic [3:0]  n_slot;
    logic        n_hit;
    logic        n_fill;
    logic        n_no_vic;

    logic        w_accept;
    logic        w_inject;
    logic        w_commit;
    logic        w_lock_ok;
    t_cell_upd   w_upd;
    logic [IW-1:0] w_upd_idx;
    logic [IW-1:0] w_upd_rank;

    // Chain positions: position k feeds cell k, position ENTRIES is the end.
    t_scan_flags   w_flags [ENTRIES+1];
    logic [IW-1:0] w_hit_idx [ENTRIES+1];
    logic [IW-1:0] w_hit_rank [ENTRIES+1];
    logic [IW-1:0] w_vic_idx [ENTRIES+1];
    logic [IW-1:0] w_vic_rank [ENTRIES+1];

    assign w_accept  = i_valid && !o_stall;
    assign w_lock_ok = ({28'd0, r_entry} < 32'(ENTRIES));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_operation == OP_LOCK) ? S_COMMIT : S_START;
                end
            end
            S_START: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_flags[ENTRIES].busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall  = 1'b1;
        w_inject = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_START: begin
                w_inject = 1'b1;
            end
            S_SCAN: begin
            end
            S_COMMIT: begin
                w_commit = !r_out_valid || !i_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_blk   <= i_block_number;
            r_entry <= i_entry_index;
        end
    end

    // Launch a fresh search record into the first cell.
    assign w_flags[0]    = '{busy: w_inject, hit: 1'b0, hit_lock: 1'b0, vic: 1'b0};
    assign w_hit_idx[0]  = '0;
    assign w_hit_rank[0] = '0;
    assign w_vic_idx[0]  = '0;
    assign w_vic_rank[0] = '0;

    // The chain of entry cells.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        lbct_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_blk      (r_blk),
            .i_flags    (w_flags[k]),
            .i_hit_idx  (w_hit_idx[k]),
            .i_hit_rank (w_hit_rank[k]),
            .i_vic_idx  (w_vic_idx[k]),
            .i_vic_rank (w_vic_rank[k]),
            .o_flags    (w_flags[k+1]),
            .o_hit_idx  (w_hit_idx[k+1]),
            .o_hit_rank (w_hit_rank[k+1]),
            .o_vic_idx  (w_vic_idx[k+1]),
            .o_vic_rank (w_vic_rank[k+1]),
            .i_upd      (w_upd),
            .i_upd_idx  (w_upd_idx),
            .i_upd_rank (w_upd_rank)
        );
    end

    // Capture the record as it leaves the last cell.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && w_flags[ENTRIES].busy) begin
            r_res      <= w_flags[ENTRIES];
            r_hit_idx  <= w_hit_idx[ENTRIES];
            r_hit_rank <= w_hit_rank[ENTRIES];
            r_vic_idx  <= w_vic_idx[ENTRIES];
            r_vic_rank <= w_vic_rank[ENTRIES];
        end
    end

    // Decide the update broadcast and the result of the request.
    always_comb begin
        w_upd      = '0;
        w_upd_idx  = '0;
        w_upd_rank = '0;
        n_slot     = '0;
        n_hit      = 1'b0;
        n_fill     = 1'b0;
        n_no_vic   = 1'b0;
        if (r_op == OP_LOCK) begin
            w_upd.lock = w_commit && w_lock_ok;
            w_upd_idx  = IW'(r_entry);
            n_slot     = r_entry;
        end else if (r_res.hit) begin
            w_upd.promote = w_commit && !r_res.hit_lock;
            w_upd_idx     = r_hit_idx;
            w_upd_rank    = r_hit_rank;
            n_slot        = 4'(r_hit_idx);
            n_hit         = 1'b1;
        end else if (r_res.vic) begin
            w_upd.promote = w_commit;
            w_upd.retag   = w_commit;
            w_upd_idx     = r_vic_idx;
            w_upd_rank    = r_vic_rank;
            n_slot        = 4'(r_vic_idx);
            n_fill        = 1'b1;
        end else begin
            n_no_vic = 1'b1;
        end
    end

    // Output register: loaded on commit, released when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_slot   <= n_slot;
            r_hit    <= n_hit;
            r_fill   <= n_fill;
            r_no_vic <= n_no_vic;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_slot        = r_slot;
    assign o_hit         = r_hit;
    assign o_fill_needed = r_fill;
    assign o_no_victim   = r_no_vic;

endmodule

// ===== design/lbct_checker.sv =====
// ----------------------------------------------------------------------------
// LRU block cache tags checker
// Port-level checks on the tag unit, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module lbct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_slot,
    input logic       o_hit,
    input logic       o_fill_needed,
    input logic       o_no_victim
);

    // A stalled result stays and keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot) && $stable(o_hit)
            && $stable(o_fill_needed) && $stable(o_no_victim))
        else $error("stalled result changed");

    // A result is a hit, a fill, a missing victim, or none of these, never two.
    a_out_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_hit, o_fill_needed, o_no_victim}))
        else $error("result carries more than one outcome");

    // A miss without a victim reports slot zero.
    a_no_vic_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_victim |-> o_slot == 4'd0)
        else $error("no-victim result with nonzero slot");

    // The unit works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while another is in work");

endmodule

bind lru_block_cache_tags_unit lbct_checker u_lbct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_slot        (o_slot),
    .o_hit         (o_hit),
    .o_fill_needed (o_fill_needed),
    .o_no_victim   (o_no_victim)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache tags unit testbench
// Drives lookup and lock requests through the valid/stall request channel.
// Every accepted result is checked field by field against an in-order
// prediction from a behavioral copy of the tags, valid bits, lock bits and
// recency ranks. A directed table opens and closes the run. Locking every
// entry is permanent and reset is applied only once, so the all-locked rows
// come last. Random requests in between run under four idling phases.
// ----------------------------------------------------------------------------
module tb;
    import lbct_pkg::*;

    localparam int N_ENTRIES       = 16;
    localparam int POOL_SIZE       = 20;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LOCK_BUDGET     = 8;

    typedef struct packed {
        logic [3:0] slot;
        logic       hit;
        logic       fill_needed;
        logic       no_victim;
    } t_tag_result;

    typedef struct {
        logic        op;
        logic [31:0] blk;
        logic [3:0]  idx;
        bit          fixed;
        t_tag_result want;
    } t_stim_row;

    // Ports of the unit under test; its inputs are known from time zero.
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic        i_operation    = OP_LOOKUP;
    logic [31:0] i_block_number = '0;
    logic [3:0]  i_entry_index  = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [3:0]  o_slot;
    logic        o_hit;
    logic        o_fill_needed;
    logic        o_no_victim;

    // A typed expectation travels alongside the request that it belongs to.
    bit          req_fixed = 1'b0;
    t_tag_result req_want  = '0;

    // Behavioral copy of the cache bookkeeping.
    logic [31:0] tag_mem[N_ENTRIES];
    bit          entry_valid[N_ENTRIES];
    bit          entry_locked[N_ENTRIES];
    int          entry_rank[N_ENTRIES];

    t_tag_result pending_results[$];
    t_stim_row   plan[$];
    logic [31:0] block_pool[POOL_SIZE];
    int          head_rows;
    int          errors         = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    lru_block_cache_tags_unit #(
        .ENTRIES(N_ENTRIES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_block_number(i_block_number),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_slot        (o_slot),
        .o_hit         (o_hit),
        .o_fill_needed (o_fill_needed),
        .o_no_victim   (o_no_victim)
    );

    always #4 i_clk = ~i_clk;

    // Moves an entry to the most recently used rank and closes the gap.
    function automatic void promote_entry(int e);
        int old_rank;
        old_rank = entry_rank[e];
        for (int k = 0; k < N_ENTRIES; k++) begin
            if (entry_rank[k] > old_rank) begin
                entry_rank[k] = entry_rank[k] - 1;
            end
        end
        entry_rank[e] = N_ENTRIES - 1;
    endfunction

    // Applies one request to the bookkeeping and returns the result it gives.
    function automatic t_tag_result resolve_request(logic op, logic [31:0] blk,
                                                    logic [3:0] idx);
        t_tag_result r;
        int          victim;
        r = '0;
        if (op == OP_LOCK) begin
            entry_locked[idx] = 1'b1;
            r.slot = idx;
            return r;
        end
        // Every valid entry takes part in the search, locked ones too.
        for (int e = 0; e < N_ENTRIES; e++) begin
            if (entry_valid[e] && tag_mem[e] == blk) begin
                if (!entry_locked[e]) begin
                    promote_entry(e);
                end
                r.slot = e[3:0];
                r.hit  = 1'b1;
                return r;
            end
        end
        // Miss: the least recently used unlocked entry is replaced.
        victim = -1;
        for (int e = 0; e < N_ENTRIES; e++) begin
            if (!entry_locked[e] && (victim < 0 || entry_rank[e] < entry_rank[victim])) begin
                victim = e;
            end
        end
        if (victim < 0) begin
            r.no_victim = 1'b1;
            return r;
        end
        tag_mem[victim]     = blk;
        entry_valid[victim] = 1'b1;
        promote_entry(victim);
        r.slot        = victim[3:0];
        r.fill_needed = 1'b1;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic add_row(logic op, logic [31:0] blk, logic [3:0] idx, bit fixed,
                           logic [3:0] slot, logic hit, logic fill, logic nov);
        t_stim_row row;
        row.op               = op;
        row.blk              = blk;
        row.idx              = idx;
        row.fixed            = fixed;
        row.want.slot        = slot;
        row.want.hit         = hit;
        row.want.fill_needed = fill;
        row.want.no_victim   = nov;
        plan.push_back(row);
    endtask

    // Presents one request after a random idle stretch and holds it until taken.
    task automatic send_request(logic op, logic [31:0] blk, logic [3:0] idx, bit fixed,
                                t_tag_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_block_number <= blk;
        i_entry_index  <= idx;
        req_fixed      <= fixed;
        req_want       <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Mostly lookups from a small pool so that hits and evictions both occur;
    // locks are rare since they remove entries from replacement for good.
    task automatic random_request();
        logic [3:0]  idx;
        logic [31:0] blk;
        int          nlocked;
        if ($urandom_range(999) < 15) begin
            nlocked = 0;
            for (int e = 0; e < N_ENTRIES; e++) begin
                if (entry_locked[e]) begin
                    nlocked++;
                end
            end
            idx = 4'($urandom_range(N_ENTRIES - 1));
            if (nlocked >= LOCK_BUDGET) begin
                while (!entry_locked[idx]) begin
                    idx = 4'($urandom_range(N_ENTRIES - 1));
                end
            end
            send_request(OP_LOCK, $urandom, idx, 1'b0, '0);
        end else begin
            if ($urandom_range(99) < 75) begin
                blk = block_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                blk = $urandom;
            end
            send_request(OP_LOOKUP, blk, 4'($urandom_range(15)), 1'b0, '0);
        end
    endtask

    // Result side stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Checks results in order and predicts each accepted request.
    always @(posedge i_clk) begin : monitor
        t_tag_result got;
        t_tag_result predicted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = {o_slot, o_hit, o_fill_needed, o_no_victim};
                if (pending_results.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected result: expected none, ",
                              "actual slot %0d hit %0b fill %0b no_victim %0b"},
                             $time, got.slot, got.hit, got.fill_needed, got.no_victim);
                end else begin
                    predicted = pending_results.pop_front();
                    check_field("slot", predicted.slot, got.slot);
                    check_field("hit", predicted.hit, got.hit);
                    check_field("fill_needed", predicted.fill_needed, got.fill_needed);
                    check_field("no_victim", predicted.no_victim, got.no_victim);
                end
            end
            if (i_valid && !o_stall) begin
                predicted = resolve_request(i_operation, i_block_number, i_entry_index);
                pending_results.push_back(req_fixed ? req_want : predicted);
            end
        end
    end

    initial begin : stimulus
        int phase_send[4];
        int phase_recv[4];
        phase_send = '{0, 45, 0, 13};
        phase_recv = '{0, 0, 45, 13};

        // Bookkeeping starts in its reset state.
        for (int e = 0; e < N_ENTRIES; e++) begin
            tag_mem[e]      = '0;
            entry_valid[e]  = 1'b0;
            entry_locked[e] = 1'b0;
            entry_rank[e]   = e;
        end

        // Opening rows: fills from reset order, hits, locks and a locked hit.
        add_row(OP_LOOKUP, 32'h0000_0000, 4'h0, 1'b1, 4'd0, 1'b0, 1'b1, 1'b0);
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 4'hF, 1'b1, 4'd1, 1'b0, 1'b1, 1'b0);
        add_row(OP_LOOKUP, 32'h0000_0000, 4'hF, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 4'h0, 1'b1, 4'd1, 1'b1, 1'b0, 1'b0);
        add_row(OP_LOCK,   32'hFFFF_FFFF, 4'h0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOCK,   32'h0000_0000, 4'h0, 1'b1, 4'd0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'h0000_0000, 4'hA, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
        add_row(OP_LOCK,   32'h5555_5555, 4'hF, 1'b1, 4'd15, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'h0000_0001, 4'h5, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'hFFFF_FFFE, 4'hA, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'hA5A5_A5A5, 4'h5, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'h0000_0001, 4'hA, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        head_rows = plan.size();

        // Closing rows: lock entries 1-14, then lookups that hit or see no victim.
        for (int e = 1; e < N_ENTRIES - 1; e++) begin
            add_row(OP_LOCK, 32'h0F0F_0F0F, e[3:0], 1'b1, e[3:0], 1'b0, 1'b0, 1'b0);
        end
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 4'h3, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'h8000_0001, 4'hC, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row(OP_LOOKUP, 32'h0000_0000, 4'h6, 1'b0, '0, 1'b0, 1'b0, 1'b0);

        block_pool[0] = 32'h0000_0000;
        block_pool[1] = 32'hFFFF_FFFF;
        for (int p = 2; p < POOL_SIZE; p++) begin
            block_pool[p] = $urandom;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < head_rows; r++) begin
            send_request(plan[r].op, plan[r].blk, plan[r].idx, plan[r].fixed, plan[r].want);
        end
        wait_drained();

        // Random requests under each idling phase, draining between phases.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            for (int p = 0; p < 4; p++) begin
                block_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
            end
            repeat (ITEMS_PER_PHASE) random_request();
            wait_drained();
        end

        send_idle_pct  = 13;
        recv_stall_pct = 13;
        for (int r = head_rows; r < plan.size(); r++) begin
            send_request(plan[r].op, plan[r].blk, plan[r].idx, plan[r].fixed, plan[r].want);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lbct_pkg.sv
design/lbct_cell.sv
design/lru_block_cache_tags_unit.sv
design/lbct_checker.sv
tb/tb.sv
